// ===== src/gcfh_pkg.sv =====
// Shared constants, register codes and types of the grid cell first-hit detector.
// No dependencies; every other file imports this package.
package gcfh_pkg;

  localparam int unsigned COORD_BITS = 12;
  localparam int unsigned CFG_W      = 12;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned COLOR_W    = 8;
  localparam int unsigned CELL_W     = 6;
  localparam int unsigned DIVD_W     = COORD_BITS + 1;

  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CELL_SIZE = 2'd2;

  localparam logic [CFG_W-1:0] CELL_SIZE_RST = 12'd32;

  // One kept pixel: ceiling-division dividends and divisor plus what the hit reports.
  typedef struct packed {
    logic [DIVD_W-1:0]     divd_x;
    logic [DIVD_W-1:0]     divd_y;
    logic [CFG_W-1:0]      divisor;
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
    logic [COLOR_W-1:0]    blue;
    logic [COLOR_W-1:0]    green;
    logic [COLOR_W-1:0]    red;
  } gcfh_item_t;

  typedef struct packed {
    logic clearing;
  } gcfh_status_t;

endpackage

// ===== src/gcfh_ifs.sv =====
// Stream interfaces of the detector: pixel input, hit output, register writes.
// Depends on gcfh_pkg.
interface gcfh_pix_if import gcfh_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] pixel_x;
  logic [COORD_BITS-1:0] pixel_y;
  logic                  foreground;
  logic [COLOR_W-1:0]    blue;
  logic [COLOR_W-1:0]    green;
  logic [COLOR_W-1:0]    red;

  modport source (output valid, pixel_x, pixel_y, foreground, blue, green, red, input ready);
  modport sink   (input valid, pixel_x, pixel_y, foreground, blue, green, red, output ready);
endinterface

interface gcfh_hit_if import gcfh_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic                  hit;
  logic [CELL_W-1:0]     cell_col;
  logic [CELL_W-1:0]     cell_row;
  logic [COORD_BITS-1:0] hit_x;
  logic [COORD_BITS-1:0] hit_y;
  logic [COLOR_W-1:0]    hit_blue;
  logic [COLOR_W-1:0]    hit_green;
  logic [COLOR_W-1:0]    hit_red;

  modport source (output valid, hit, cell_col, cell_row, hit_x, hit_y, hit_blue, hit_green,
                  hit_red, input ready);
  modport sink   (input valid, hit, cell_col, cell_row, hit_x, hit_y, hit_blue, hit_green,
                  hit_red, output ready);
endinterface

interface gcfh_cfg_if import gcfh_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== src/gcfh_front.sv =====
// Front end: configuration registers, pixel accept, drop filtering and grid range check.
// Depends on gcfh_pkg and gcfh_ifs; feeds kept pixels into the queue.
module gcfh_front import gcfh_pkg::*; #(
  parameter int unsigned GRID_SIDE = 64
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  gcfh_pix_if.sink       pix_i,
  gcfh_cfg_if.sink       cfg_i,
  input  gcfh_status_t   status_i,
  input  logic           q_full_i,
  output logic           q_push_o,
  output gcfh_item_t     q_item_o
);

  localparam int unsigned LIM_W = CFG_W + $clog2(GRID_SIDE + 1);

  logic [CFG_W-1:0]      origin_x_q, origin_y_q, cell_size_q;
  logic [CFG_W-1:0]      divisor;
  logic [LIM_W-1:0]      limit;
  logic [COORD_BITS-1:0] off_x, off_y;
  logic [DIVD_W-1:0]     divd_x, divd_y;
  logic                  below, in_grid, accept;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_x_q  <= '0;
      origin_y_q  <= '0;
      cell_size_q <= CELL_SIZE_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_ORIGIN_X:  origin_x_q  <= cfg_i.data;
        REG_ORIGIN_Y:  origin_y_q  <= cfg_i.data;
        REG_CELL_SIZE: cell_size_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  assign divisor = (cell_size_q == '0) ? CFG_W'(1) : cell_size_q;
  assign limit   = LIM_W'(LIM_W'(divisor) * LIM_W'(GRID_SIDE));

  assign below = (pix_i.pixel_x < origin_x_q) || (pix_i.pixel_y < origin_y_q);
  assign off_x = pix_i.pixel_x - origin_x_q;
  assign off_y = pix_i.pixel_y - origin_y_q;
  assign divd_x = DIVD_W'(off_x) + DIVD_W'(divisor) - DIVD_W'(1);
  assign divd_y = DIVD_W'(off_y) + DIVD_W'(divisor) - DIVD_W'(1);
  assign in_grid = (LIM_W'(divd_x) < limit) && (LIM_W'(divd_y) < limit);

  assign pix_i.ready = !q_full_i && !status_i.clearing;
  assign accept      = pix_i.valid && pix_i.ready;
  assign q_push_o    = accept && pix_i.foreground && !below && in_grid;

  assign q_item_o.divd_x  = divd_x;
  assign q_item_o.divd_y  = divd_y;
  assign q_item_o.divisor = divisor;
  assign q_item_o.pixel_x = pix_i.pixel_x;
  assign q_item_o.pixel_y = pix_i.pixel_y;
  assign q_item_o.blue    = pix_i.blue;
  assign q_item_o.green   = pix_i.green;
  assign q_item_o.red     = pix_i.red;

endmodule

// ===== src/gcfh_queue.sv =====
// Two-entry queue of kept pixels between front and back end.
// Depends on gcfh_pkg.
module gcfh_queue import gcfh_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  gcfh_item_t item_i,
  output logic       full_o,
  input  logic       pop_i,
  output logic       empty_o,
  output gcfh_item_t item_o
);

  gcfh_item_t  mem_q [2];
  logic        wr_ptr_q, rd_ptr_q;
  logic [1:0]  cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign item_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

endmodule

// ===== src/gcfh_back.sv =====
// Back end: restoring ceiling divider for both axes, occupancy RAM with clear sweep,
// and the hit output register. Depends on gcfh_pkg and gcfh_ifs.
module gcfh_back import gcfh_pkg::*; #(
  parameter int unsigned GRID_SIDE = 64
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         q_empty_i,
  input  gcfh_item_t   q_item_i,
  output logic         q_pop_o,
  output gcfh_status_t status_o,
  gcfh_hit_if.source   hit_o
);

  localparam int unsigned QW     = $clog2(GRID_SIDE);
  localparam int unsigned CNT_W  = $clog2(QW + 1);
  localparam int unsigned DS_W   = CFG_W + QW;
  localparam int unsigned DEPTH  = GRID_SIDE * GRID_SIDE;
  localparam int unsigned ADDR_W = $clog2(DEPTH);

  localparam logic [2:0] ST_CLR  = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_DIV  = 3'd2;
  localparam logic [2:0] ST_RD   = 3'd3;
  localparam logic [2:0] ST_CHK  = 3'd4;

  logic [2:0]        state_q, state_d;
  logic [ADDR_W-1:0] clr_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [DIVD_W-1:0] rem_x_q, rem_y_q;
  logic [DS_W-1:0]   ds_q;
  logic [QW-1:0]     qx_q, qy_q;
  gcfh_item_t        item_q;

  logic              occ_mem [DEPTH];
  logic              occ_rd_q;
  logic [ADDR_W-1:0] cell_addr, mem_addr;
  logic              mem_we, mem_wdata;

  logic [DS_W-1:0]   rx_ext, ry_ext;
  logic              ge_x, ge_y;
  logic              out_free, take;

  logic                  out_valid_q;
  logic [CELL_W-1:0]     col_q, row_q;
  logic [COORD_BITS-1:0] hx_q, hy_q;
  logic [COLOR_W-1:0]    hb_q, hg_q, hr_q;

  assign rx_ext = DS_W'(rem_x_q);
  assign ry_ext = DS_W'(rem_y_q);
  assign ge_x   = rx_ext >= ds_q;
  assign ge_y   = ry_ext >= ds_q;

  assign cell_addr = ADDR_W'(ADDR_W'(qy_q) * ADDR_W'(GRID_SIDE)) + ADDR_W'(qx_q);
  assign out_free  = !out_valid_q || hit_o.ready;
  assign take      = (state_q == ST_CHK) && !occ_rd_q && out_free;

  assign q_pop_o           = (state_q == ST_IDLE) && !q_empty_i;
  assign status_o.clearing = (state_q == ST_CLR);

  assign mem_addr  = (state_q == ST_CLR) ? clr_q : cell_addr;
  assign mem_we    = (state_q == ST_CLR) || take;
  assign mem_wdata = (state_q != ST_CLR);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      occ_mem[mem_addr] <= mem_wdata;
    end
    occ_rd_q <= occ_mem[mem_addr];
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLR:  if (clr_q == ADDR_W'(DEPTH - 1)) state_d = ST_IDLE;
      ST_IDLE: if (!q_empty_i) state_d = ST_DIV;
      ST_DIV:  if (cnt_q == '0) state_d = ST_RD;
      ST_RD:   state_d = ST_CHK;
      ST_CHK:  if (occ_rd_q || out_free) state_d = ST_IDLE;
      default: state_d = ST_CLR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLR) begin
        clr_q <= clr_q + ADDR_W'(1);
      end
      if (take) begin
        out_valid_q <= 1'b1;
      end else if (hit_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      item_q  <= q_item_i;
      rem_x_q <= q_item_i.divd_x;
      rem_y_q <= q_item_i.divd_y;
      ds_q    <= DS_W'(q_item_i.divisor) << (QW - 1);
      cnt_q   <= CNT_W'(QW - 1);
      qx_q    <= '0;
      qy_q    <= '0;
    end else if (state_q == ST_DIV) begin
      if (ge_x) rem_x_q <= DIVD_W'(rx_ext - ds_q);
      if (ge_y) rem_y_q <= DIVD_W'(ry_ext - ds_q);
      qx_q  <= QW'({qx_q, ge_x});
      qy_q  <= QW'({qy_q, ge_y});
      ds_q  <= ds_q >> 1;
      cnt_q <= cnt_q - CNT_W'(1);
    end
    if (take) begin
      col_q <= CELL_W'(qx_q);
      row_q <= CELL_W'(qy_q);
      hx_q  <= item_q.pixel_x;
      hy_q  <= item_q.pixel_y;
      hb_q  <= item_q.blue;
      hg_q  <= item_q.green;
      hr_q  <= item_q.red;
    end
  end

  assign hit_o.valid     = out_valid_q;
  assign hit_o.hit       = 1'b1;
  assign hit_o.cell_col  = col_q;
  assign hit_o.cell_row  = row_q;
  assign hit_o.hit_x     = hx_q;
  assign hit_o.hit_y     = hy_q;
  assign hit_o.hit_blue  = hb_q;
  assign hit_o.hit_green = hg_q;
  assign hit_o.hit_red   = hr_q;

  a_no_pop_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLR) |-> !q_pop_o)
    else $error("queue popped during clear sweep");

  a_set_only_in_chk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we && mem_wdata) |-> (state_q == ST_CHK) && !occ_rd_q)
    else $error("occupancy set outside check of a clear cell");

  a_hit_from_chk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == ST_CHK)
    else $error("hit raised without a cell check");

  a_div_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (cnt_q < CNT_W'(QW)))
    else $error("divider step count out of range");

endmodule

// ===== src/grid_cell_first_hit_detector_core.sv =====
// Top level of the grid cell first-hit detector: front end, queue, back end.
// Depends on gcfh_pkg, gcfh_ifs, gcfh_front, gcfh_queue and gcfh_back.
//
//  channel  dir  beat
//  pix_i    in   pixel_x, pixel_y, foreground, blue, green, red
//  cfg_i    in   index (0 origin_x, 1 origin_y, 2 cell_size), data
//  hit_o    out  hit, cell_col, cell_row, hit_x, hit_y, hit_blue, hit_green, hit_red
//
// Dropped pixels (background, before the origin, off the grid) never enter the queue.
// The back end takes one kept pixel at a time through the pop in idle, the one-bit-per-cycle
// divider, the occupancy RAM read and the check that sets a clear cell and raises its hit.
// After reset a clear sweep over all GRID_SIDE * GRID_SIDE cells holds pix_i.ready low.
// A two-entry queue and the hit output register let either side stall on its own.
module grid_cell_first_hit_detector_core import gcfh_pkg::*; #(
  parameter int unsigned GRID_SIDE = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  gcfh_pix_if.sink   pix_i,
  gcfh_cfg_if.sink   cfg_i,
  gcfh_hit_if.source hit_o
);

  gcfh_status_t status;
  gcfh_item_t   push_item, pop_item;
  logic         q_full, q_push, q_empty, q_pop;

  gcfh_front #(.GRID_SIDE(GRID_SIDE)) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .pix_i    (pix_i),
    .cfg_i    (cfg_i),
    .status_i (status),
    .q_full_i (q_full),
    .q_push_o (q_push),
    .q_item_o (push_item)
  );

  gcfh_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (push_item),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .item_o  (pop_item)
  );

  gcfh_back #(.GRID_SIDE(GRID_SIDE)) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_empty),
    .q_item_i  (pop_item),
    .q_pop_o   (q_pop),
    .status_o  (status),
    .hit_o     (hit_o)
  );

endmodule
